### rtl/core/julia_escape_time_pixel_defines.svh
// Assertion macros shared by the escape-time pixel engine.
// Synthesis builds define SYNTH, and every macro then expands to nothing.
`ifndef JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH

`ifndef SYNTH

// The property must hold at every rising clock edge outside reset.
`define JETP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define JETP_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error(msg);

`else

`define JETP_ASSERT(name, clk, rst_n, prop, msg)
`define JETP_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

### rtl/core/jetp_pkg.sv
`default_nettype none

package jetp_pkg;

  // Number formats. Complex values are signed fixed point.
  localparam int VALUE_BITS    = 32;
  localparam int FRACTION_BITS = 28;
  localparam int COORD_BITS    = 11;
  localparam int STEP_BITS     = 31;
  localparam int LIMIT_BITS    = 31;
  localparam int ITER_BITS     = 9;
  localparam int COLOR_BITS    = 8;
  localparam int RGB_BITS      = 3 * COLOR_BITS;

  // The palette depth is a power of two, so the count indexes it by its low bits.
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_IDX_BITS  = $clog2(PALETTE_DEPTH);

  // A truncated square of a full-range value fits in PROD_BITS bits.
  localparam int PROD_BITS  = 2 * VALUE_BITS - 1 - FRACTION_BITS;
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam int START_BITS = COORD_BITS + STEP_BITS + 2;
  localparam int WIDE_BITS  = 48;

  // Request queue between the front and the back.
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = 1;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = VALUE_BITS;

  localparam logic [ITER_BITS-1:0] MAX_ITER_CAP = 9'd256;
  localparam logic [ITER_BITS-1:0] MAX_ITER_MIN = 9'd1;

  // Register reset values.
  localparam logic signed [VALUE_BITS-1:0] REAL_MIN_RST   = -32'sd402653184;
  localparam logic signed [VALUE_BITS-1:0] IMAG_MIN_RST   = -32'sd402653184;
  localparam logic [STEP_BITS-1:0]         REAL_STEP_RST  = 31'd786432;
  localparam logic [STEP_BITS-1:0]         IMAG_STEP_RST  = 31'd786432;
  localparam logic signed [VALUE_BITS-1:0] C_REAL_RST     = -32'sd199984418;
  localparam logic signed [VALUE_BITS-1:0] C_IMAG_RST     = 32'sd26843546;
  localparam logic [LIMIT_BITS-1:0]        ESC_LIMIT_RST  = 31'd1073741824;
  localparam logic [ITER_BITS-1:0]         MAX_ITER_RST   = 9'd256;

  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_PIXEL   = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_REAL_MIN     = 3'd0,
    REG_IMAG_MIN     = 3'd1,
    REG_REAL_STEP    = 3'd2,
    REG_IMAG_STEP    = 3'd3,
    REG_C_REAL       = 3'd4,
    REG_C_IMAG       = 3'd5,
    REG_ESCAPE_LIMIT = 3'd6,
    REG_MAX_ITER     = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_READ,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    op_e                     operation;
    logic [COORD_BITS-1:0]   pixel_x;
    logic [COORD_BITS-1:0]   pixel_y;
    logic [PAL_IDX_BITS-1:0] palette_index;
    logic [COLOR_BITS-1:0]   red_in;
    logic [COLOR_BITS-1:0]   green_in;
    logic [COLOR_BITS-1:0]   blue_in;
  } in_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x_out;
    logic [COORD_BITS-1:0] pixel_y_out;
    logic [ITER_BITS-1:0]  iter_count;
    logic                  in_set;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } out_res_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    op_e                           operation;
    logic [COORD_BITS-1:0]         pixel_x;
    logic [COORD_BITS-1:0]         pixel_y;
    logic signed [VALUE_BITS-1:0]  z_re;
    logic signed [VALUE_BITS-1:0]  z_im;
    logic [PAL_IDX_BITS-1:0]       pal_idx;
    logic [RGB_BITS-1:0]           rgb;
  } job_t;

  // Settings that the iteration loop needs.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] c_real;
    logic signed [VALUE_BITS-1:0] c_imag;
    logic [LIMIT_BITS-1:0]        escape_limit;
    logic [ITER_BITS-1:0]         max_iter;
  } back_cfg_t;

  // Clamp a wide signed value to the signed VALUE_BITS range.
  function automatic logic signed [VALUE_BITS-1:0] sat_value(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    logic signed [VALUE_BITS-1:0] res;
    hi = {{(WIDE_BITS - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      res = hi[VALUE_BITS-1:0];
    end else if (v < lo) begin
      res = lo[VALUE_BITS-1:0];
    end else begin
      res = v[VALUE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/jetp_cmul.sv
`default_nettype none

// Registered complex square products: re*re, im*im and re*im, each truncated
// toward zero to the fraction width.
module jetp_cmul (
  input  wire logic                                  clk_i,
  input  wire logic signed [jetp_pkg::VALUE_BITS-1:0] re_i,
  input  wire logic signed [jetp_pkg::VALUE_BITS-1:0] im_i,
  output logic [jetp_pkg::PROD_BITS-1:0]             rr_o,
  output logic [jetp_pkg::PROD_BITS-1:0]             ii_o,
  output logic signed [jetp_pkg::PROD_BITS:0]        ri_o
);

  localparam int VB = jetp_pkg::VALUE_BITS;
  localparam int FB = jetp_pkg::FRACTION_BITS;
  localparam int PB = jetp_pkg::PROD_BITS;

  logic [VB-1:0]   re_mag;
  logic [VB-1:0]   im_mag;
  logic [2*VB-1:0] p_rr;
  logic [2*VB-1:0] p_ii;
  logic [2*VB-1:0] p_ri;
  logic [PB-1:0]   ri_mag;
  logic            ri_neg;

  // Work on magnitudes so that truncation goes toward zero.
  assign re_mag = re_i[VB-1] ? (~unsigned'(re_i) + 1'b1) : unsigned'(re_i);
  assign im_mag = im_i[VB-1] ? (~unsigned'(im_i) + 1'b1) : unsigned'(im_i);

  assign p_rr = (2*VB)'(re_mag) * (2*VB)'(re_mag);
  assign p_ii = (2*VB)'(im_mag) * (2*VB)'(im_mag);
  assign p_ri = (2*VB)'(re_mag) * (2*VB)'(im_mag);

  // The top product bit is always zero, since each magnitude is at most 2^(VB-1).
  assign ri_mag = p_ri[2*VB-2:FB];
  assign ri_neg = re_i[VB-1] ^ im_i[VB-1];

  always_ff @(posedge clk_i) begin
    rr_o <= p_rr[2*VB-2:FB];
    ii_o <= p_ii[2*VB-2:FB];
    ri_o <= ri_neg ? -signed'({1'b0, ri_mag}) : signed'({1'b0, ri_mag});
  end

endmodule

`default_nettype wire

### rtl/core/jetp_queue.sv
`default_nettype none

// Short FIFO of classified requests between the front and the back.
module jetp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire jetp_pkg::job_t push_data_i,
  input  wire logic           pop_i,
  output jetp_pkg::job_t      head_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int Depth   = jetp_pkg::QUEUE_DEPTH;
  localparam int PtrBits = jetp_pkg::QUEUE_PTR_BITS;

  jetp_pkg::job_t     mem_q [Depth];
  logic [PtrBits-1:0] wptr_q, wptr_d;
  logic [PtrBits-1:0] rptr_q, rptr_d;
  logic [PtrBits:0]   count_q, count_d;

  assign full_o  = (count_q == (PtrBits + 1)'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrBits'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrBits'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/jetp_front.sv
`default_nettype none

// Front end: holds the configuration registers, classifies each request and
// maps a pixel to its saturated start point before it enters the queue.
module jetp_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire jetp_pkg::in_req_t                   in_data_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [jetp_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [jetp_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output logic                                     push_o,
  output jetp_pkg::job_t                           push_job_o,
  input  wire logic                                q_full_i,
  output jetp_pkg::back_cfg_t                      back_cfg_o
);

  localparam int VB = jetp_pkg::VALUE_BITS;
  localparam int CB = jetp_pkg::COORD_BITS;
  localparam int SB = jetp_pkg::STEP_BITS;
  localparam int TB = jetp_pkg::START_BITS;
  localparam int WB = jetp_pkg::WIDE_BITS;

  logic signed [VB-1:0]                  real_min_q;
  logic signed [VB-1:0]                  imag_min_q;
  logic [SB-1:0]                         real_step_q;
  logic [SB-1:0]                         imag_step_q;
  logic signed [VB-1:0]                  c_real_q;
  logic signed [VB-1:0]                  c_imag_q;
  logic [jetp_pkg::LIMIT_BITS-1:0]       escape_limit_q;
  logic [jetp_pkg::ITER_BITS-1:0]        max_iter_q;
  logic [jetp_pkg::ITER_BITS-1:0]        max_eff;

  logic [CB+SB-1:0]     off_re;
  logic [CB+SB-1:0]     off_im;
  logic signed [TB-1:0] start_re;
  logic signed [TB-1:0] start_im;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_min_q     <= jetp_pkg::REAL_MIN_RST;
      imag_min_q     <= jetp_pkg::IMAG_MIN_RST;
      real_step_q    <= jetp_pkg::REAL_STEP_RST;
      imag_step_q    <= jetp_pkg::IMAG_STEP_RST;
      c_real_q       <= jetp_pkg::C_REAL_RST;
      c_imag_q       <= jetp_pkg::C_IMAG_RST;
      escape_limit_q <= jetp_pkg::ESC_LIMIT_RST;
      max_iter_q     <= jetp_pkg::MAX_ITER_RST;
    end else if (cfg_valid_i) begin
      case (jetp_pkg::cfg_reg_e'(cfg_index_i))
        jetp_pkg::REG_REAL_MIN:     real_min_q     <= cfg_data_i[VB-1:0];
        jetp_pkg::REG_IMAG_MIN:     imag_min_q     <= cfg_data_i[VB-1:0];
        jetp_pkg::REG_REAL_STEP:    real_step_q    <= cfg_data_i[SB-1:0];
        jetp_pkg::REG_IMAG_STEP:    imag_step_q    <= cfg_data_i[SB-1:0];
        jetp_pkg::REG_C_REAL:       c_real_q       <= cfg_data_i[VB-1:0];
        jetp_pkg::REG_C_IMAG:       c_imag_q       <= cfg_data_i[VB-1:0];
        jetp_pkg::REG_ESCAPE_LIMIT: escape_limit_q <= cfg_data_i[jetp_pkg::LIMIT_BITS-1:0];
        jetp_pkg::REG_MAX_ITER:     max_iter_q     <= cfg_data_i[jetp_pkg::ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A maximum of zero acts as one, and anything above the cap acts as the cap.
  always_comb begin
    if (max_iter_q == '0) begin
      max_eff = jetp_pkg::MAX_ITER_MIN;
    end else if (max_iter_q > jetp_pkg::MAX_ITER_CAP) begin
      max_eff = jetp_pkg::MAX_ITER_CAP;
    end else begin
      max_eff = max_iter_q;
    end
  end

  assign back_cfg_o.c_real       = c_real_q;
  assign back_cfg_o.c_imag       = c_imag_q;
  assign back_cfg_o.escape_limit = escape_limit_q;
  assign back_cfg_o.max_iter     = max_eff;

  // Start point: window minimum plus coordinate times step, then saturated.
  assign off_re   = (CB+SB)'(in_data_i.pixel_x) * (CB+SB)'(real_step_q);
  assign off_im   = (CB+SB)'(in_data_i.pixel_y) * (CB+SB)'(imag_step_q);
  assign start_re = signed'({{(TB - VB){real_min_q[VB-1]}}, real_min_q})
                  + signed'({2'b00, off_re});
  assign start_im = signed'({{(TB - VB){imag_min_q[VB-1]}}, imag_min_q})
                  + signed'({2'b00, off_im});

  always_comb begin
    push_job_o.operation = in_data_i.operation;
    push_job_o.pixel_x   = in_data_i.pixel_x;
    push_job_o.pixel_y   = in_data_i.pixel_y;
    push_job_o.z_re      = jetp_pkg::sat_value(
                             signed'({{(WB - TB){start_re[TB-1]}}, start_re}));
    push_job_o.z_im      = jetp_pkg::sat_value(
                             signed'({{(WB - TB){start_im[TB-1]}}, start_im}));
    push_job_o.pal_idx   = in_data_i.palette_index;
    push_job_o.rgb       = {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
  end

  // A request enters the queue whenever there is room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

### rtl/core/jetp_back.sv
`default_nettype none

`include "julia_escape_time_pixel_defines.svh"

// Back end: palette writes, the z = z*z + c loop, the palette lookup and the
// result register.
module jetp_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_empty_i,
  input  wire jetp_pkg::job_t      q_head_i,
  output logic                     pop_o,
  input  wire jetp_pkg::back_cfg_t back_cfg_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output jetp_pkg::out_res_t       out_data_o
);

  localparam int VB = jetp_pkg::VALUE_BITS;
  localparam int PB = jetp_pkg::PROD_BITS;
  localparam int SM = jetp_pkg::SUM_BITS;
  localparam int WB = jetp_pkg::WIDE_BITS;
  localparam int IB = jetp_pkg::ITER_BITS;
  localparam int XB = jetp_pkg::PAL_IDX_BITS;
  localparam int KB = jetp_pkg::COLOR_BITS;
  localparam int GB = jetp_pkg::RGB_BITS;

  jetp_pkg::back_state_e state_q, state_d;

  logic [IB-1:0]        count_q, count_d;
  logic [IB-1:0]        count_inc;
  logic signed [VB-1:0] z_re_q;
  logic signed [VB-1:0] z_im_q;
  logic [jetp_pkg::COORD_BITS-1:0] px_q;
  logic [jetp_pkg::COORD_BITS-1:0] py_q;

  logic [PB-1:0]        rr;
  logic [PB-1:0]        ii;
  logic signed [PB:0]   ri;
  logic signed [SM-1:0] sum_re;
  logic signed [SM-1:0] sum_im;
  logic signed [VB-1:0] new_re;
  logic signed [VB-1:0] new_im;
  logic [PB:0]          mag2;
  logic                 esc_hit;

  logic                 pal_we;
  logic                 load_z;
  logic                 do_step;
  logic                 rd_en;
  logic                 out_free;
  logic                 out_load;
  logic                 out_valid_q;
  logic                 in_set;
  logic [GB-1:0]        rgb;

  logic [GB-1:0]        pal_mem [jetp_pkg::PALETTE_DEPTH];
  logic [GB-1:0]        rd_data_q;
  jetp_pkg::out_res_t   out_q;

  // Shared complex square unit.
  jetp_cmul u_cmul (
    .clk_i (clk_i),
    .re_i  (z_re_q),
    .im_i  (z_im_q),
    .rr_o  (rr),
    .ii_o  (ii),
    .ri_o  (ri)
  );

  // One step of z*z + c with saturation, and the squared magnitude of z.
  assign sum_re = signed'({2'b00, rr}) - signed'({2'b00, ii})
                + signed'({{(SM - VB){back_cfg_i.c_real[VB-1]}}, back_cfg_i.c_real});
  assign sum_im = signed'({ri, 1'b0})
                + signed'({{(SM - VB){back_cfg_i.c_imag[VB-1]}}, back_cfg_i.c_imag});
  assign new_re = jetp_pkg::sat_value(signed'({{(WB - SM){sum_re[SM-1]}}, sum_re}));
  assign new_im = jetp_pkg::sat_value(signed'({{(WB - SM){sum_im[SM-1]}}, sum_im}));
  assign mag2   = {1'b0, rr} + {1'b0, ii};

  // The start point is never tested for escape, only the points after a step.
  assign esc_hit = (count_q != '0)
                && (mag2 > {{(PB + 1 - jetp_pkg::LIMIT_BITS){1'b0}}, back_cfg_i.escape_limit});

  assign count_inc = count_q + 1'b1;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      jetp_pkg::ST_IDLE: begin
        if (!q_empty_i && (q_head_i.operation == jetp_pkg::OP_PIXEL)) begin
          state_d = jetp_pkg::ST_MUL;
        end
      end
      jetp_pkg::ST_MUL: begin
        state_d = jetp_pkg::ST_STEP;
      end
      jetp_pkg::ST_STEP: begin
        if (esc_hit || (count_inc == back_cfg_i.max_iter)) begin
          state_d = jetp_pkg::ST_READ;
        end else begin
          state_d = jetp_pkg::ST_MUL;
        end
      end
      jetp_pkg::ST_READ: begin
        state_d = jetp_pkg::ST_FIN;
      end
      jetp_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = jetp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = jetp_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o    = 1'b0;
    pal_we   = 1'b0;
    load_z   = 1'b0;
    do_step  = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      jetp_pkg::ST_IDLE: begin
        pop_o  = !q_empty_i;
        pal_we = !q_empty_i && (q_head_i.operation == jetp_pkg::OP_PALETTE);
        load_z = !q_empty_i && (q_head_i.operation == jetp_pkg::OP_PIXEL);
      end
      jetp_pkg::ST_STEP: begin
        do_step = !esc_hit;
      end
      jetp_pkg::ST_READ: begin
        rd_en = 1'b1;
      end
      jetp_pkg::ST_FIN: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // The count is cleared when a pixel is loaded and only advances on a step that finds no escape.
  always_comb begin
    count_d = count_q;
    if (load_z) begin
      count_d = '0;
    end else if (do_step) begin
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jetp_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Iterate registers.
  always_ff @(posedge clk_i) begin
    if (load_z) begin
      z_re_q <= q_head_i.z_re;
      z_im_q <= q_head_i.z_im;
      px_q   <= q_head_i.pixel_x;
      py_q   <= q_head_i.pixel_y;
    end else if (do_step) begin
      z_re_q <= new_re;
      z_im_q <= new_im;
    end
  end

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[q_head_i.pal_idx] <= q_head_i.rgb;
    end
    if (rd_en) begin
      rd_data_q <= pal_mem[count_q[XB-1:0]];
    end
  end

  // Result register. A point that ran to the maximum is black.
  assign in_set = (count_q == back_cfg_i.max_iter);
  assign rgb    = in_set ? '0 : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pixel_x_out <= px_q;
      out_q.pixel_y_out <= py_q;
      out_q.iter_count  <= count_q;
      out_q.in_set      <= in_set;
      out_q.red         <= rgb[GB-1 -: KB];
      out_q.green       <= rgb[2*KB-1 -: KB];
      out_q.blue        <= rgb[KB-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The count never runs past the maximum while a pixel is in progress.
  `JETP_ASSERT(a_count_bound, clk_i, rst_ni,
    (state_q != jetp_pkg::ST_IDLE) |-> (count_q <= back_cfg_i.max_iter),
    "iteration count exceeds the maximum")

  // A step always uses products registered in the cycle before.
  `JETP_ASSERT(a_step_after_mul, clk_i, rst_ni,
    (state_q == jetp_pkg::ST_STEP) |-> ($past(state_q) == jetp_pkg::ST_MUL),
    "step without fresh products")

  // Finishing a pixel presents a result and frees the back end.
  `JETP_ASSERT(a_finish_result, clk_i, rst_ni,
    (state_q == jetp_pkg::ST_FIN && out_free)
      |=> (out_valid_q && state_q == jetp_pkg::ST_IDLE),
    "finished pixel did not reach the result register")

  // An in-set result is black.
  `JETP_ASSERT(a_in_set_black, clk_i, rst_ni,
    (out_valid_o && out_data_o.in_set)
      |-> (out_data_o.red == '0 && out_data_o.green == '0 && out_data_o.blue == '0),
    "in-set result carries a color")

  // Every result has done at least one step.
  `JETP_ASSERT_NEVER(a_no_zero_count, clk_i, rst_ni,
    out_valid_o && (out_data_o.iter_count == '0),
    "result with zero iterations")

endmodule

`default_nettype wire

### rtl/core/julia_escape_time_pixel.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o   in_data_i (palette write or pixel)
// out       output     out_valid_o / out_stall_i out_data_o (one result per pixel)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A pixel holds the engine until it runs to the maximum or escapes. Each step
// takes a square state and an add and saturate state, and one more pair detects
// an escape; the pop comes before the steps, and the palette read and the result
// load after them. A palette write is done as its request is popped.
// A finished pixel waits while the previous result is held by out_stall_i.
// Reset is asynchronous and active low; palette entries are undefined until written.
`default_nettype none

module julia_escape_time_pixel (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire jetp_pkg::in_req_t                   in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output jetp_pkg::out_res_t                       out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [jetp_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [jetp_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  logic                push;
  jetp_pkg::job_t      push_job;
  logic                pop;
  jetp_pkg::job_t      q_head;
  logic                q_full;
  logic                q_empty;
  jetp_pkg::back_cfg_t back_cfg;

  // Request intake, configuration and start point mapping.
  jetp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_job_o  (push_job),
    .q_full_i    (q_full),
    .back_cfg_o  (back_cfg)
  );

  // Queue between intake and the iteration engine.
  jetp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Iteration engine, palette and result register.
  jetp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .back_cfg_i  (back_cfg),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
